// ----- rtl/core/msod_pkg.sv -----
// Package with the constants, types and edge functions of the square overlap depth block.
package msod_pkg;

   localparam int MAX_SQUARES = 128;
   localparam int COORD_BITS  = 32;
   localparam int FIELD_BITS  = 32;
   localparam int OUT_BITS    = 8;
   localparam int IDX_W       = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;
   localparam int CNT_W       = $clog2(MAX_SQUARES + 1);
   localparam int EDGE_W      = COORD_BITS + 2;
   localparam int SQ_W        = 3 * COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [EDGE_W-1:0]     edge_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef struct packed {
      logic    ram_we;
      idx_type ram_waddr;
      idx_type ram_raddr;
      logic    latch_px;
      logic    latch_py;
      logic    clear_cnt;
      logic    scan_issue;
      logic    update_best;
      logic    clear_best;
      logic    load_rsp;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   function automatic edge_type low_edge(coord_type c, coord_type s);
      low_edge = (EDGE_W'(c) << 1) + (EDGE_W'(1) << COORD_BITS) - EDGE_W'(s);
   endfunction

   function automatic edge_type high_edge(coord_type c, coord_type s);
      high_edge = (EDGE_W'(c) << 1) + (EDGE_W'(1) << COORD_BITS) + EDGE_W'(s);
   endfunction

endpackage

// ----- rtl/core/msod_if.sv -----
// Handshake interfaces for the square items and the result items.
interface msod_req_if import msod_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] center_x;
   logic [FIELD_BITS-1:0] center_y;
   logic [FIELD_BITS-1:0] side;
   logic                  last;
   modport source (output valid, center_x, center_y, side, last, input ready);
   modport sink (input valid, center_x, center_y, side, last, output ready);
endinterface

interface msod_rsp_if import msod_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] max_overlap;
   modport source (output valid, max_overlap, input ready);
   modport sink (input valid, max_overlap, output ready);
endinterface

// ----- rtl/core/msod_ram.sv -----
// Generic single write port RAM with a registered read port.
module msod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/msod_ctrl.sv -----
// Controller that loads squares and sequences the candidate point scans.
module msod_ctrl import msod_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_FI    = 3'd1;
   localparam logic [2:0] S_FJ    = 3'd2;
   localparam logic [2:0] S_LJ    = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_NEXT  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   cnt_type    count_ff, count_in;
   idx_type    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic       fi_wait_ff, fi_wait_in;
   logic       accept;
   logic       i_end, j_end, k_end;

   assign accept = req_valid && req_ready;
   assign i_end  = (CNT_W'(i_ff) + CNT_W'(1)) >= count_ff;
   assign j_end  = (CNT_W'(j_ff) + CNT_W'(1)) >= count_ff;
   assign k_end  = (CNT_W'(k_ff) + CNT_W'(1)) >= count_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      fi_wait_in = 1'b0;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.ram_waddr = count_ff[IDX_W-1:0];
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (accept) begin
               if (count_ff < CNT_W'(MAX_SQUARES)) begin
                  cmd.ram_we = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  cmd.clear_best = 1'b1;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = S_FI;
               end
            end
         end
         S_FI: begin
            cmd.ram_raddr = i_ff;
            cmd.latch_px  = fi_wait_ff;
            fi_wait_in    = !fi_wait_ff;
            if (fi_wait_ff) begin
               state_in = S_FJ;
            end
         end
         S_FJ: begin
            cmd.ram_raddr = j_ff;
            state_in      = S_LJ;
         end
         S_LJ: begin
            cmd.latch_py  = 1'b1;
            cmd.clear_cnt = 1'b1;
            k_in          = '0;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.ram_raddr  = k_ff;
            cmd.scan_issue = 1'b1;
            k_in           = k_ff + IDX_W'(1);
            if (k_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_NEXT;
         end
         S_NEXT: begin
            cmd.update_best = 1'b1;
            if (!j_end) begin
               j_in     = j_ff + IDX_W'(1);
               state_in = S_FJ;
            end else if (!i_end) begin
               j_in     = '0;
               i_in     = i_ff + IDX_W'(1);
               state_in = S_FI;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               count_in     = '0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         fi_wait_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         fi_wait_ff <= fi_wait_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end
endmodule

// ----- rtl/core/msod_dp.sv -----
// Datapath with the square store, edge arithmetic, cover counter and result register.
module msod_dp import msod_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [FIELD_BITS-1:0] req_center_x,
   input  logic [FIELD_BITS-1:0] req_center_y,
   input  logic [FIELD_BITS-1:0] req_side,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_BITS-1:0]   rsp_max_overlap
);
   logic [SQ_W-1:0]     wdata, rdata;
   coord_type           cx, cy, cs;
   edge_type            lx, hx, ly, hy;
   edge_type            px_ff, py_ff;
   logic                scan_vld_ff;
   cnt_type             cnt_ff, best_ff;
   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] rsp_data_ff;
   logic                inside_pt;

   assign wdata = {req_side[COORD_BITS-1:0], req_center_y[COORD_BITS-1:0],
                   req_center_x[COORD_BITS-1:0]};

   msod_ram #(.WIDTH(SQ_W), .DEPTH(MAX_SQUARES)) u_store (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (cmd.ram_waddr),
      .wdata (wdata),
      .raddr (cmd.ram_raddr),
      .rdata (rdata)
   );

   assign cx = rdata[COORD_BITS-1:0];
   assign cy = rdata[2*COORD_BITS-1:COORD_BITS];
   assign cs = rdata[3*COORD_BITS-1:2*COORD_BITS];
   assign lx = low_edge(cx, cs);
   assign hx = high_edge(cx, cs);
   assign ly = low_edge(cy, cs);
   assign hy = high_edge(cy, cs);
   assign inside_pt = (lx <= px_ff) && (px_ff <= hx) && (ly <= py_ff) && (py_ff <= hy);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         scan_vld_ff <= cmd.scan_issue;
         if (cmd.clear_cnt) begin
            cnt_ff <= '0;
         end else if (scan_vld_ff && inside_pt) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.clear_best) begin
            best_ff <= '0;
         end else if (cmd.update_best && (cnt_ff > best_ff)) begin
            best_ff <= cnt_ff;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.latch_px) begin
         px_ff <= lx;
      end
      if (cmd.latch_py) begin
         py_ff <= ly;
      end
      if (cmd.load_rsp) begin
         if (32'(best_ff) > 32'((1 << OUT_BITS) - 1)) begin
            rsp_data_ff <= '1;
         end else begin
            rsp_data_ff <= OUT_BITS'(best_ff);
         end
      end
   end

   assign status.rsp_busy = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_overlap = rsp_data_ff;
endmodule

// ----- rtl/core/max_square_overlap_depth_core.sv -----
// Top level of the square overlap depth block.
// The req channel takes one square per item: center_x, center_y, side and last.
// Squares are stored at one item per cycle; up to 128 are kept and later ones
// are dropped, but an item with last set always closes the set.
// After the item with last set, the block stops taking items and tries every
// candidate point formed by the lower x edge of one square and the lower y edge
// of any square. For each point it reads the whole square store through its single
// read port and counts the squares that contain the point.
// With n stored squares a set reads the whole store once for each of its n*n
// candidate points, through the one read port of the square store.
// The rsp channel then carries one item holding the largest count.
// The result waits in an output register until the receiver takes it; while it
// waits the next set is loaded, and a finished set holds until the register frees.
// Reset empties the store count, drops any pending result and returns to loading.
module max_square_overlap_depth_core import msod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   msod_req_if.sink    req,
   msod_rsp_if.source  rsp
);
   cmd_type    cmd;
   status_type status;

   msod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msod_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_center_x    (req.center_x),
      .req_center_y    (req.center_y),
      .req_side        (req.side),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_max_overlap (rsp.max_overlap)
   );

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("Result pending after reset.");
   a_rsp_from_ctrl: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.load_rsp))
      else $error("Result raised without a load command.");
   a_no_load_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> !req.ready)
      else $error("Input taken during a scan.");
endmodule
